// File: hw/rtl/mstb_pkg.sv
// mstb_pkg: shared types and constants for the software timer bank
// no dependencies; imported by multi_software_timer_bank_core
`default_nettype none

package mstb_pkg;

    // default bank geometry
    localparam int DEF_NUM_TIMERS = 16;
    localparam int DEF_COUNT_BITS = 16;

    // fixed field widths of the stream payloads
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 16;

    // input tdata layout: slot, period, periodic, zero fill to 24 bits
    localparam int IN_SLOT_LSB     = 0;
    localparam int IN_PERIOD_LSB   = IN_SLOT_LSB + SLOT_W;
    localparam int IN_PERIODIC_BIT = IN_PERIOD_LSB + PERIOD_W;
    localparam int IN_DATA_W       = 24;

    // output tdata layout: result_slot, is_started, is_completed, no_free_slot
    localparam int OUT_DATA_W = 8;

    // action codes carried in s_tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 3'd0,
        ACT_ALLOCATE = 3'd1,
        ACT_START    = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_RELEASE  = 3'd4,
        ACT_QUERY    = 3'd5
    } action_t;

endpackage

`default_nettype wire

// File: hw/rtl/multi_software_timer_bank_core.sv
// multi_software_timer_bank_core: bank of one-shot / periodic software timers
// sequenced over a single slot walker with period and count memories
// depends on mstb_pkg
//
// usage
//   slave channel s_*: one transaction carries one action in s_tuser
//   (tick, allocate, start, stop, release, query) and its arguments in s_tdata
//   master channel m_*: exactly one result transaction per action
//   s_tready is high only while the sequencer is idle; one action at a time
// steps from acceptance to m_tvalid, with the receiver ready
//   stop, release, query, unknown code: applied on acceptance, then finish
//   start on a slot in use: apply, then finish
//   allocate, or start on a free slot: scan from slot 0 for the lowest free slot,
//     then apply (no_free_slot when the bank is full), one slot checked per cycle
//   tick: read stage then process stage over every slot, one slot read and at most
//     one written per cycle through the count memory port pair
// a new action is taken once the sequencer is back in idle, even while the
// previous result still sits in the output register
// when the receiver stalls, the finished result waits in the sequencer and the
// output register holds; nothing is dropped
// reset clears every slot flag; count and period memories need no clearing pass
`default_nettype none

module multi_software_timer_bank_core
    import mstb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // slot[3:0], period[19:4], periodic[20]
    input  wire logic [ACTION_W-1:0]   s_tuser,  // action[2:0]
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata   // result_slot[3:0], is_started[4],
                                                 // is_completed[5], no_free_slot[6]
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TICK   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // sequencer and operand registers
    state_t                 state_reg, state_next;
    action_t                op_action_reg, op_action_next;
    logic [COUNT_BITS-1:0]  op_period_reg, op_period_next;
    logic                   op_periodic_reg, op_periodic_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]       found_idx_reg, found_idx_next;

    // tick walker: read stage and process stage
    logic                   rd_active_reg, rd_active_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pipe_v_reg, pipe_v_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;

    // per-slot flags
    logic [NUM_TIMERS-1:0]  in_use_reg, in_use_next;
    logic [NUM_TIMERS-1:0]  started_reg, started_next;
    logic [NUM_TIMERS-1:0]  completed_reg, completed_next;
    logic [NUM_TIMERS-1:0]  reloads_reg, reloads_next;

    // pending result
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic                   res_started_reg, res_started_next;
    logic                   res_completed_reg, res_completed_next;
    logic                   res_full_reg, res_full_next;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // count and period memories; a count is only used for a slot in use, and
    // taking a slot always writes its count first, so no reset is needed
    logic [COUNT_BITS-1:0]  remaining_mem [NUM_TIMERS];
    logic [COUNT_BITS-1:0]  period_mem    [NUM_TIMERS];
    logic [COUNT_BITS-1:0]  remaining_rd_reg;
    logic [COUNT_BITS-1:0]  period_rd_reg;

    logic                   rem_we;
    logic [IDX_W-1:0]       rem_waddr;
    logic [COUNT_BITS-1:0]  rem_wdata;
    logic                   per_we;
    logic [IDX_W-1:0]       per_waddr;
    logic [COUNT_BITS-1:0]  per_wdata;

    // input decode
    logic                   in_accept;
    logic [SLOT_W-1:0]      in_slot;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_slot_ok;
    logic                   out_free;

    // tick arithmetic on the slot in the process stage
    logic [COUNT_BITS-1:0]  tick_dec;
    logic                   tick_hit;
    logic                   tick_zero;

    assign in_accept  = s_tvalid && s_tready;
    assign in_slot    = s_tdata[IN_SLOT_LSB +: SLOT_W];
    assign in_idx     = IDX_W'(in_slot);
    assign in_slot_ok = (32'(in_slot) < NUM_TIMERS);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared decrement and zero test
    assign tick_dec  = started_reg[pipe_idx_reg] ? (remaining_rd_reg - CNT_ONE)
                                                 : remaining_rd_reg;
    assign tick_hit  = in_use_reg[pipe_idx_reg] && (remaining_rd_reg != '0);
    assign tick_zero = (tick_dec == '0);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        op_action_next     = op_action_reg;
        op_period_next     = op_period_reg;
        op_periodic_next   = op_periodic_reg;
        scan_idx_next      = scan_idx_reg;
        found_idx_next     = found_idx_reg;
        rd_active_next     = 1'b0;
        rd_idx_next        = rd_idx_reg;
        pipe_v_next        = 1'b0;
        pipe_idx_next      = rd_idx_reg;
        in_use_next        = in_use_reg;
        started_next       = started_reg;
        completed_next     = completed_reg;
        reloads_next       = reloads_reg;
        res_slot_next      = res_slot_reg;
        res_started_next   = res_started_reg;
        res_completed_next = res_completed_reg;
        res_full_next      = res_full_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;
        rem_we             = 1'b0;
        rem_waddr          = found_idx_reg;
        rem_wdata          = '0;
        per_we             = 1'b0;
        per_waddr          = found_idx_reg;
        per_wdata          = op_period_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_action_next     = action_t'(s_tuser);
                    op_period_next     = COUNT_BITS'(s_tdata[IN_PERIOD_LSB +: PERIOD_W]);
                    op_periodic_next   = s_tdata[IN_PERIODIC_BIT];
                    res_slot_next      = '0;
                    res_started_next   = 1'b0;
                    res_completed_next = 1'b0;
                    res_full_next      = 1'b0;
                    state_next         = ST_FINISH;
                    unique case (action_t'(s_tuser))
                        ACT_TICK:
                        begin
                            rd_active_next = 1'b1;
                            rd_idx_next    = '0;
                            state_next     = ST_TICK;
                        end
                        ACT_ALLOCATE:
                        begin
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        ACT_START:
                        begin
                            if (in_slot_ok && in_use_reg[in_idx])
                            begin
                                found_idx_next = in_idx;
                                state_next     = ST_APPLY;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        ACT_STOP:
                        begin
                            res_slot_next = in_slot;
                            if (in_slot_ok)
                            begin
                                started_next[in_idx]   = 1'b0;
                                completed_next[in_idx] = 1'b0;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            res_slot_next = in_slot;
                            if (in_slot_ok)
                            begin
                                in_use_next[in_idx]    = 1'b0;
                                started_next[in_idx]   = 1'b0;
                                completed_next[in_idx] = 1'b0;
                            end
                        end
                        ACT_QUERY:
                        begin
                            res_slot_next = in_slot;
                            if (in_slot_ok)
                            begin
                                res_started_next       = started_reg[in_idx];
                                res_completed_next     = completed_reg[in_idx];
                                completed_next[in_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unknown codes return an all-zero result
                        end
                    endcase
                end
            end

            ST_TICK:
            begin
                // read stage: fetch the next slot's count and period
                if (rd_active_reg)
                begin
                    pipe_v_next   = 1'b1;
                    pipe_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_active_next = 1'b0;
                    end
                    else
                    begin
                        rd_active_next = 1'b1;
                        rd_idx_next    = rd_idx_reg + 1'b1;
                    end
                end
                // process stage: count down, complete, reload or stop
                if (pipe_v_reg && tick_hit)
                begin
                    rem_we    = 1'b1;
                    rem_waddr = pipe_idx_reg;
                    rem_wdata = tick_dec;
                    if (tick_zero)
                    begin
                        completed_next[pipe_idx_reg] = 1'b1;
                        if (reloads_reg[pipe_idx_reg])
                        begin
                            rem_wdata = period_rd_reg;
                        end
                        else
                        begin
                            started_next[pipe_idx_reg] = 1'b0;
                        end
                    end
                end
                if (pipe_v_reg && !rd_active_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_SCAN:
            begin
                // one slot checked per cycle for the lowest free one
                if (!in_use_reg[scan_idx_reg])
                begin
                    found_idx_next = scan_idx_reg;
                    state_next     = ST_APPLY;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    res_full_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_APPLY:
            begin
                in_use_next[found_idx_reg] = 1'b1;
                res_slot_next              = SLOT_W'(found_idx_reg);
                rem_we                     = 1'b1;
                if (op_action_reg == ACT_START)
                begin
                    started_next[found_idx_reg]   = 1'b1;
                    completed_next[found_idx_reg] = (op_period_reg == '0);
                    reloads_next[found_idx_reg]   = op_periodic_reg;
                    rem_wdata                     = op_period_reg;
                    per_we                        = 1'b1;
                end
                else
                begin
                    started_next[found_idx_reg]   = 1'b0;
                    completed_next[found_idx_reg] = 1'b0;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hand the result over once the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_full_reg, res_completed_reg,
                                     res_started_reg, res_slot_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_active_reg <= 1'b0;
            pipe_v_reg    <= 1'b0;
            in_use_reg    <= '0;
            started_reg   <= '0;
            completed_reg <= '0;
            reloads_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_active_reg <= rd_active_next;
            pipe_v_reg    <= pipe_v_next;
            in_use_reg    <= in_use_next;
            started_reg   <= started_next;
            completed_reg <= completed_next;
            reloads_reg   <= reloads_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // operand, index and payload registers
    always_ff @(posedge clk)
    begin
        op_action_reg     <= op_action_next;
        op_period_reg     <= op_period_next;
        op_periodic_reg   <= op_periodic_next;
        scan_idx_reg      <= scan_idx_next;
        found_idx_reg     <= found_idx_next;
        rd_idx_reg        <= rd_idx_next;
        pipe_idx_reg      <= pipe_idx_next;
        res_slot_reg      <= res_slot_next;
        res_started_reg   <= res_started_next;
        res_completed_reg <= res_completed_next;
        res_full_reg      <= res_full_next;
        m_tdata_reg       <= m_tdata_next;
    end

    // count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            remaining_mem[rem_waddr] <= rem_wdata;
        end
        remaining_rd_reg <= remaining_mem[rd_idx_reg];
    end

    // period memory: written on start, read by the tick walker
    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[per_waddr] <= per_wdata;
        end
        period_rd_reg <= period_mem[rd_idx_reg];
    end

`ifndef NO_ASSERTIONS
    // an accepted action always takes the sequencer out of idle in the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("sequencer still ready right after accepting an action");

    // running or completed flags only exist on slots in use
    a_flags_need_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((started_reg | completed_reg) & ~in_use_reg) == '0
    ) else $error("flag set on a free slot");

    // the tick walker has drained before a result is handed over
    a_walker_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!pipe_v_reg && !rd_active_reg)
    ) else $error("tick walker still active at result hand-over");

    // a result appears only after the sequencer has finished an action
    a_result_from_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FINISH)
    ) else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire

// File: bench/multi_software_timer_bank_core_tb.sv
`timescale 1ns / 1ps
// multi_software_timer_bank_core_tb: stream-level bench for the software timer bank
// keeps its own copy of the slot flags and counts, predicts every result, checks it
// depends on mstb_pkg and multi_software_timer_bank_core

module multi_software_timer_bank_core_tb;
    import mstb_pkg::*;

    localparam int NUM_SLOTS      = DEF_NUM_TIMERS;
    localparam int CNT_W          = DEF_COUNT_BITS;
    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    // longest action plus the longest output stall, with ample margin
    localparam int DRAIN_CYCLES   = 2 * (DEF_NUM_TIMERS + 13) + 8;

    // action codes the block has no meaning for
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    // result field positions in m_tdata
    localparam int OUT_STARTED_BIT   = SLOT_W;
    localparam int OUT_COMPLETED_BIT = SLOT_W + 1;
    localparam int OUT_FULL_BIT      = SLOT_W + 2;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
    } timer_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              started;
        logic              completed;
        logic              full;
    } timer_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // slot[3:0], period[19:4], periodic[20]
    logic [ACTION_W-1:0]   s_tuser = '0;   // action[2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // result_slot[3:0], is_started[4],
                                           // is_completed[5], no_free_slot[6]

    // predicted bank state
    bit               slot_busy [NUM_SLOTS];
    bit               running   [NUM_SLOTS];
    bit               done_flag [NUM_SLOTS];
    bit               reload_mode [NUM_SLOTS];
    logic [CNT_W-1:0] reload_value [NUM_SLOTS];
    logic [CNT_W-1:0] count_left [NUM_SLOTS];

    timer_cmd_t   action_queue[$];
    timer_reply_t timer_replies[$];

    int  error_count = 0;
    int  quiet_cycles = 0;
    int  cmds_sent = 0;
    int  results_seen = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;

    multi_software_timer_bank_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // idle cycles before the next transaction; no idling in every fourth stretch
    function automatic int draw_wait(int n);
        if (n % 64 < 16)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic int lowest_free_slot();
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_busy[i])
                return i;
        return -1;
    endfunction

    function automatic void claim_slot(int s);
        slot_busy[s]  = 1'b1;
        running[s]    = 1'b0;
        done_flag[s]  = 1'b0;
        count_left[s] = '0;
    endfunction

    // advance the predicted bank by one action and return the result it gives
    function automatic timer_reply_t apply_timer_action(timer_cmd_t cmd);
        timer_reply_t r;
        int s;
        r = '0;
        case (cmd.action)
            ACT_TICK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_busy[i] && count_left[i] != 0)
                    begin
                        if (running[i])
                            count_left[i] = count_left[i] - 1'b1;
                        if (count_left[i] == 0)
                        begin
                            if (reload_mode[i])
                                count_left[i] = reload_value[i];
                            else
                                running[i] = 1'b0;
                            done_flag[i] = 1'b1;
                        end
                    end
                end
            end
            ACT_ALLOCATE:
            begin
                s = lowest_free_slot();
                if (s < 0)
                    r.full = 1'b1;
                else
                begin
                    claim_slot(s);
                    r.slot = s[SLOT_W-1:0];
                end
            end
            ACT_START:
            begin
                // a free slot falls back to the lowest free one
                if (slot_busy[cmd.slot])
                    s = int'(cmd.slot);
                else
                begin
                    s = lowest_free_slot();
                    if (s >= 0)
                        claim_slot(s);
                end
                if (s < 0)
                    r.full = 1'b1;
                else
                begin
                    reload_value[s] = cmd.period;
                    reload_mode[s]  = cmd.periodic;
                    running[s]      = 1'b1;
                    done_flag[s]    = (cmd.period == 0);
                    count_left[s]   = cmd.period;
                    r.slot          = s[SLOT_W-1:0];
                end
            end
            ACT_STOP:
            begin
                r.slot = cmd.slot;
                running[cmd.slot]   = 1'b0;
                done_flag[cmd.slot] = 1'b0;
            end
            ACT_RELEASE:
            begin
                r.slot = cmd.slot;
                slot_busy[cmd.slot]  = 1'b0;
                running[cmd.slot]    = 1'b0;
                done_flag[cmd.slot]  = 1'b0;
                count_left[cmd.slot] = '0;
            end
            ACT_QUERY:
            begin
                r.slot      = cmd.slot;
                r.started   = running[cmd.slot];
                r.completed = done_flag[cmd.slot];
                done_flag[cmd.slot] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [ACTION_W-1:0] action, logic [SLOT_W-1:0] slot,
                             logic [PERIOD_W-1:0] period, logic periodic);
        timer_cmd_t c;
        c.action   = action;
        c.slot     = slot;
        c.period   = period;
        c.periodic = periodic;
        action_queue.push_back(c);
    endtask

    // weighted action mix; filling phases favor allocate/start, draining ones release
    function automatic logic [ACTION_W-1:0] pick_action(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return (roll == 0) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
        if (roll < 28)
            return ACT_TICK;
        if (filling)
        begin
            if (roll < 48) return ACT_ALLOCATE;
            if (roll < 78) return ACT_START;
            if (roll < 83) return ACT_STOP;
            if (roll < 88) return ACT_RELEASE;
            return ACT_QUERY;
        end
        if (roll < 33) return ACT_ALLOCATE;
        if (roll < 48) return ACT_START;
        if (roll < 58) return ACT_STOP;
        if (roll < 83) return ACT_RELEASE;
        return ACT_QUERY;
    endfunction

    // input driver: one transaction at a time, random gap before each
    always @(negedge clk)
    begin
        timer_cmd_t c;
        logic [IN_DATA_W-1:0] d;
        if (rst_n)
        begin
            if (s_tvalid && in_taken)
            begin
                cmds_sent++;
                gap_left = draw_wait(cmds_sent);
            end
            if (!s_tvalid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (action_queue.size() != 0)
                begin
                    c = action_queue.pop_front();
                    d = '0;
                    d[IN_SLOT_LSB +: SLOT_W]     = c.slot;
                    d[IN_PERIOD_LSB +: PERIOD_W] = c.period;
                    d[IN_PERIODIC_BIT]           = c.periodic;
                    s_tdata  <= d;
                    s_tuser  <= c.action;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                results_seen++;
                stall_left = draw_wait(results_seen + 32);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transactions, check output transactions, watchdog
    always @(posedge clk)
    begin : monitor
        timer_cmd_t   cmd;
        timer_reply_t want;
        if (rst_n)
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;

            // check result
            if (m_tvalid && m_tready)
            begin
                if (timer_replies.size() == 0)
                    report_mismatch("result with nothing expected, tdata", int'(m_tdata), 0);
                else
                begin
                    want = timer_replies.pop_front();
                    if (m_tdata[SLOT_W-1:0] !== want.slot)
                        report_mismatch("result_slot", int'(m_tdata[SLOT_W-1:0]),
                                        int'(want.slot));
                    if (m_tdata[OUT_STARTED_BIT] !== want.started)
                        report_mismatch("is_started", int'(m_tdata[OUT_STARTED_BIT]),
                                        int'(want.started));
                    if (m_tdata[OUT_COMPLETED_BIT] !== want.completed)
                        report_mismatch("is_completed", int'(m_tdata[OUT_COMPLETED_BIT]),
                                        int'(want.completed));
                    if (m_tdata[OUT_FULL_BIT] !== want.full)
                        report_mismatch("no_free_slot", int'(m_tdata[OUT_FULL_BIT]),
                                        int'(want.full));
                end
            end

            // predict result of the accepted action
            if (s_tvalid && s_tready)
            begin
                cmd.action   = s_tuser;
                cmd.slot     = s_tdata[IN_SLOT_LSB +: SLOT_W];
                cmd.period   = s_tdata[IN_PERIOD_LSB +: PERIOD_W];
                cmd.periodic = s_tdata[IN_PERIODIC_BIT];
                timer_replies.push_back(apply_timer_action(cmd));
            end

            // watchdog on cycles without any transaction
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [PERIOD_W-1:0] period;

        // directed: empty bank, zero period, periodic reload, stop, release, odd codes
        queue_cmd(ACT_TICK,     4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_STOP,     4'd15, 16'h0000, 1'b0);
        queue_cmd(ACT_ALLOCATE, 4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_START,    4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_START,    4'd9,  16'h0001, 1'b1);
        queue_cmd(ACT_START,    4'd14, 16'h0002, 1'b0);
        queue_cmd(ACT_TICK,     4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_TICK,     4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd1,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd2,  16'h0000, 1'b0);
        queue_cmd(ACT_STOP,     4'd1,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd1,  16'h0000, 1'b0);
        queue_cmd(ACT_TICK,     4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_START,    4'd1,  16'hFFFF, 1'b1);
        queue_cmd(ACT_RELEASE,  4'd2,  16'h0000, 1'b0);
        queue_cmd(ACT_QUERY,    4'd2,  16'h0000, 1'b0);
        queue_cmd(ACT_ALLOCATE, 4'd0,  16'h0000, 1'b0);
        queue_cmd(ACT_UNUSED_LO, 4'd15, 16'hFFFF, 1'b1);
        queue_cmd(ACT_UNUSED_HI, 4'd15, 16'hFFFF, 1'b1);
        queue_cmd(ACT_RELEASE,  4'd15, 16'h0000, 1'b0);
        queue_cmd(ACT_TICK,     4'd15, 16'hFFFF, 1'b1);

        // random: alternating fill and drain phases, mostly short periods
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0:       period = PERIOD_W'($urandom);
                1, 2:    period = PERIOD_W'($urandom_range(5, 40));
                default: period = PERIOD_W'($urandom_range(0, 4));
            endcase
            queue_cmd(pick_action(((i / 40) % 2) == 0), SLOT_W'($urandom_range(0, 15)),
                      period, 1'($urandom_range(0, 1)));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (action_queue.size() != 0 || s_tvalid || timer_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (timer_replies.size() != 0)
            report_mismatch("results never delivered", timer_replies.size(), 0);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
